/* hw/rtl/scancode_to_char_with_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Scancode translator assertion macros
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_CHAR_WITH_BUFFER_ASSERT_SVH
`define SCANCODE_TO_CHAR_WITH_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SCTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SCTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sctc_pkg.sv */
// ----------------------------------------------------------------------------
// Scancode translator package
// Request/result types, key codes, LED masks and the set 1 keymap tables.
// ----------------------------------------------------------------------------
package sctc_pkg;

  // Character buffer: BUFFER_DEPTH slots, FIFO_CAP usable; the count tells full from empty
  localparam int unsigned BUFFER_DEPTH = 32;
  localparam int unsigned PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned FIFO_CAP     = BUFFER_DEPTH - 1;

  // Request opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Key codes (scancode with the break bit stripped)
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] KEY_NUM    = 7'h45;
  localparam logic [6:0] KEY_SCROLL = 7'h46;
  localparam logic [6:0] KEY_BSLASH = 7'h2B;
  localparam logic [6:0] KEY_SLASH  = 7'h35;
  localparam logic [6:0] KEY_PAD_LO = 7'h47;
  localparam logic [6:0] KEY_PAD_HI = 7'h51;
  localparam int unsigned KEY_COUNT = 84;

  // LED bits
  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  // Characters used by the caps lock fixups
  localparam logic [7:0] CH_NOKEY  = 8'h80;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef struct packed {
    logic       op;
    logic [7:0] scan_byte;
  } req_t;

  typedef struct packed {
    logic             char_valid;
    logic [7:0]       char_out;
    logic             overflow_drop;
    logic [CNT_W-1:0] chars_held;
    logic [2:0]       led_bits;
  } res_t;

  // Translator to buffer: character to enqueue
  typedef struct packed {
    logic       req;
    logic [7:0] ch;
  } push_t;

  localparam logic [7:0] MAP_PLAIN [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h80,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
    8'h5C, 8'h79, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h2C, 8'h2E, 8'h2F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80, 8'h34,
    8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  localparam logic [7:0] MAP_SHIFT [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h80,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
    8'h7C, 8'h59, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h3C, 8'h3E, 8'h5F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80, 8'h34,
    8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  // Keymap lookup. Caps lock flips the case of letters, swaps the
  // backslash/pipe key, turns '_' on the slash key into '?' when shifted,
  // and blanks the keypad (except 0 and Del) when unshifted.
  function automatic logic [7:0] key_map(input logic [6:0] key,
                                         input logic       shift,
                                         input logic       caps);
    logic [7:0] base;
    logic       letter;
    base   = 8'h00;
    letter = 1'b0;
    if (key < 7'(KEY_COUNT)) begin
      base   = shift ? MAP_SHIFT[key] : MAP_PLAIN[key];
      letter = (base >= 8'h61 && base <= 8'h7A) || (base >= 8'h41 && base <= 8'h5A);
      if (caps) begin
        if (letter) begin
          base = base ^ CASE_BIT;
        end else if (key == KEY_BSLASH) begin
          base = shift ? CH_BSLASH : CH_PIPE;
        end else if (key == KEY_SLASH && shift) begin
          base = CH_QMARK;
        end else if (!shift && key >= KEY_PAD_LO && key <= KEY_PAD_HI) begin
          base = CH_NOKEY;
        end
      end
    end
    return base;
  endfunction

endpackage

/* hw/rtl/sctc_xlate.sv */
// ----------------------------------------------------------------------------
// Scancode translator: key decode
// Tracks shift and lock LEDs and maps make codes to characters.
// ----------------------------------------------------------------------------
module sctc_xlate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  sctc_pkg::req_t req_i,
  output sctc_pkg::push_t push_o,
  output logic [2:0]    led_bits_o
);
  import sctc_pkg::*;

  logic       shift_q, shift_d;
  logic [2:0] leds_q, leds_d;
  logic [6:0] key;
  logic       make;
  logic       is_scan;
  logic [7:0] ch;

  assign key     = req_i.scan_byte[6:0];
  assign make    = !req_i.scan_byte[7];
  assign is_scan = (req_i.op == OP_SCAN);

  // Key decode; special keys first
  always_comb begin
    shift_d = shift_q;
    leds_d  = leds_q;
    ch      = 8'h00;
    if (is_scan) begin
      priority if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
        shift_d = make;
      end else if (key == KEY_CTRL || key == KEY_ALT) begin
        ch = 8'h00;
      end else if (key == KEY_CAPS) begin
        if (make) leds_d = leds_q ^ LED_CAPS;
      end else if (key == KEY_NUM) begin
        if (make) leds_d = leds_q ^ LED_NUM;
      end else if (key == KEY_SCROLL) begin
        if (make) leds_d = leds_q ^ LED_SCROLL;
      end else begin
        ch = key_map(key, shift_q, (leds_q & LED_CAPS) != 3'b000);
      end
    end
  end

  assign push_o.req  = is_scan && make && (ch != 8'h00);
  assign push_o.ch   = ch;
  assign led_bits_o  = leds_d;

  // Key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      leds_q  <= 3'b000;
    end else if (fire_i) begin
      shift_q <= shift_d;
      leds_q  <= leds_d;
    end
  end

endmodule

/* hw/rtl/sctc_fifo.sv */
// ----------------------------------------------------------------------------
// Scancode translator: character buffer
// Circular buffer of translated characters; drops on full, pops on read.
// ----------------------------------------------------------------------------
module sctc_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      pop_req_i,
  input  sctc_pkg::push_t           push_i,
  output logic                      pop_valid_o,
  output logic [7:0]                pop_char_o,
  output logic                      drop_o,
  output logic [sctc_pkg::CNT_W-1:0] held_o
);
  import sctc_pkg::*;

  logic [7:0]       mem_q [BUFFER_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full, empty;
  logic             do_push, do_pop;

  assign full    = (cnt_q == CNT_W'(FIFO_CAP));
  assign empty   = (cnt_q == '0);
  assign do_pop  = pop_req_i && !empty;
  assign do_push = push_i.req && !full;

  assign pop_valid_o = do_pop;
  assign pop_char_o  = do_pop ? mem_q[rd_ptr_q] : 8'h00;
  assign drop_o      = push_i.req && full;

  // Fill count after this request
  always_comb begin
    cnt_d = cnt_q;
    if (do_pop)  cnt_d = cnt_q - CNT_W'(1);
    if (do_push) cnt_d = cnt_q + CNT_W'(1);
  end
  assign held_o = cnt_d;

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i && do_push) begin
      mem_q[wr_ptr_q] <= push_i.ch;
    end
  end

endmodule

/* hw/rtl/sctc_outq.sv */
// ----------------------------------------------------------------------------
// Scancode translator: result queue
// Two-entry result buffer so a stalled receiver does not block the stage.
// ----------------------------------------------------------------------------
module sctc_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sctc_pkg::res_t data_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sctc_pkg::res_t out_o
);
  import sctc_pkg::*;

  res_t       head_q, tail_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign room_o      = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = head_q;
  assign pop         = out_valid_o && !out_stall_i;

  // Occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Entries: head is always the oldest
  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_q <= (push_i && cnt_q == 2'd1) ? data_i : tail_q;
      if (push_i && cnt_q == 2'd2) tail_q <= data_i;
    end else if (push_i) begin
      if (cnt_q == 2'd0) head_q <= data_i;
      else               tail_q <= data_i;
    end
  end

endmodule

/* hw/rtl/scancode_to_char_with_buffer.sv */
// ----------------------------------------------------------------------------
// Scancode set 1 to character translator with receive buffer
// Input register, key decode plus buffer update, two-entry result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on in_valid_i / in_i and are taken when in_stall_o is
//   low. op = scan: scan_byte is a set 1 code (bit 7 = release); shift and
//   lock keys update state, other make codes are translated and queued in a
//   31-character buffer (dropped with overflow_drop when full). op = read:
//   the oldest queued character is returned with char_valid.
//   Every request yields exactly one result on out_valid_o / out_o, taken
//   when out_stall_i is low; chars_held and led_bits show state after it.
//   Path: a request is held in the input register, decoded and applied to
//   the buffer, and its result is written into the result queue. Throughput:
//   one request per cycle while the result queue has room, set by the single
//   decode/buffer stage between the input register and the result queue.
//   Stall: the result queue holds two results; in_stall_o rises only when
//   both are held and a request waits in the input register.
//   Reset: shift, LEDs and the buffer are cleared; the block is ready as soon
//   as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
module scancode_to_char_with_buffer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sctc_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sctc_pkg::res_t out_o
);
  import sctc_pkg::*;

  logic       in_valid_q;
  req_t       in_q;
  logic       room;
  logic       fire;
  logic       accept;
  push_t      push;
  logic [2:0] led_bits;
  logic       pop_valid;
  logic [7:0] pop_char;
  logic       drop;
  logic [CNT_W-1:0] held;
  res_t       res;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_i;
  end

  sctc_xlate u_xlate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_i      (in_q),
    .push_o     (push),
    .led_bits_o (led_bits)
  );

  sctc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .pop_req_i   (in_q.op == OP_READ),
    .push_i      (push),
    .pop_valid_o (pop_valid),
    .pop_char_o  (pop_char),
    .drop_o      (drop),
    .held_o      (held)
  );

  // Result assembly
  always_comb begin
    res.char_valid    = pop_valid;
    res.char_out      = pop_char;
    res.overflow_drop = drop;
    res.chars_held    = held;
    res.led_bits      = led_bits;
  end

  sctc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

/* hw/rtl/sctc_chk.sv */
// ----------------------------------------------------------------------------
// Scancode translator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "scancode_to_char_with_buffer_assert.svh"

module sctc_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sctc_pkg::res_t out_o
);
  import sctc_pkg::*;

  // A stalled result stays up and unchanged
  `SCTC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "result changed under stall")

  // Input backs up only when results are waiting downstream
  `SCTC_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o, "input stalled with no result pending")

  // A read and a drop never share one result
  `SCTC_ASSERT_NOW(a_read_xor_drop, out_valid_o, !(out_o.char_valid && out_o.overflow_drop), "read and drop in one result")

  // No character without char_valid
  `SCTC_ASSERT_NOW(a_char_zero, out_valid_o && !out_o.char_valid, out_o.char_out == 8'h00, "char_out nonzero without char_valid")

  // A drop only happens at full
  `SCTC_ASSERT_NOW(a_drop_full, out_valid_o && out_o.overflow_drop, out_o.chars_held == CNT_W'(FIFO_CAP), "drop while buffer not full")

endmodule

bind scancode_to_char_with_buffer sctc_chk u_sctc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

/* dv/sctc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode translator result checker
// Watches both channels. Every accepted request runs through a local model of
// the shift/lock state and the character FIFO, and the predicted result is
// queued. Each accepted result is then compared field by field in order.
// ----------------------------------------------------------------------------
module sctc_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  sctc_pkg::req_t  in_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  sctc_pkg::res_t  out_i,
  output int              fail_count_o,
  output int              pending_o
);
  import sctc_pkg::*;

  // Set 1 keymaps: plain, shifted, caps lock, caps lock with shift
  localparam logic [7:0] KEYS_PLAIN [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h80,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
    8'h5C, 8'h79, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h2C, 8'h2E, 8'h2F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
    8'h34, 8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  localparam logic [7:0] KEYS_SHIFT [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h80,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
    8'h7C, 8'h59, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h3C, 8'h3E, 8'h5F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
    8'h34, 8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  localparam logic [7:0] KEYS_CAPS [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0A, 8'h80,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3B, 8'h27, 8'h60, 8'h80,
    8'h7C, 8'h59, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h2C, 8'h2E, 8'h2F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h30, 8'h7F
  };

  localparam logic [7:0] KEYS_CAPS_SHIFT [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0A, 8'h80,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3A, 8'h22, 8'h7E, 8'h80,
    8'h5C, 8'h79, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h3C, 8'h3E, 8'h3F, 8'h80,
    8'h2A, 8'h80, 8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h37, 8'h38, 8'h39, 8'h80,
    8'h34, 8'h35, 8'h36, 8'h80,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h7F
  };

  // Model state
  logic       shift_down;
  logic [2:0] lock_state;
  logic [7:0] typed_chars [$];
  res_t       expected_results [$];
  int         mismatches = 0;
  int         outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // Character for a key under the current shift and caps lock state
  function automatic logic [7:0] key_char(input logic [6:0] key);
    logic caps;
    caps = (lock_state & LED_CAPS) != 3'b000;
    if (key >= 7'(KEY_COUNT)) return 8'h00;
    if (shift_down) return caps ? KEYS_CAPS_SHIFT[key] : KEYS_SHIFT[key];
    return caps ? KEYS_CAPS[key] : KEYS_PLAIN[key];
  endfunction

  // Apply one request to the model and return its result
  function automatic res_t keyboard_result(input req_t r);
    res_t       res;
    logic [6:0] key;
    logic       make;
    logic [7:0] ch;
    res  = '0;
    ch   = 8'h00;
    key  = r.scan_byte[6:0];
    make = !r.scan_byte[7];
    if (r.op == OP_READ) begin
      // empty read returns nothing and changes nothing
      if (typed_chars.size() != 0) begin
        res.char_valid = 1'b1;
        res.char_out   = typed_chars.pop_front();
      end
    end else begin
      if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
        shift_down = make;
      end else if (key == KEY_CTRL || key == KEY_ALT) begin
        // modifiers without effect
      end else if (key == KEY_CAPS) begin
        if (make) lock_state = lock_state ^ LED_CAPS;
      end else if (key == KEY_NUM) begin
        if (make) lock_state = lock_state ^ LED_NUM;
      end else if (key == KEY_SCROLL) begin
        if (make) lock_state = lock_state ^ LED_SCROLL;
      end else begin
        ch = key_char(key);
      end
      // only a make with a nonzero character is queued; full FIFO drops it
      if (make && ch != 8'h00) begin
        if (typed_chars.size() >= FIFO_CAP) res.overflow_drop = 1'b1;
        else typed_chars.push_back(ch);
      end
    end
    res.chars_held = CNT_W'(typed_chars.size());
    res.led_bits   = lock_state;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Score results against predictions, then record the new request
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      shift_down = 1'b0;
      lock_state = 3'b000;
      typed_chars.delete();
      expected_results.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result 0x%0h arrived with no request outstanding", out_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("char_valid", want.char_valid, out_i.char_valid);
          check_field("char_out", want.char_out, out_i.char_out);
          check_field("overflow_drop", want.overflow_drop, out_i.overflow_drop);
          check_field("chars_held", want.chars_held, out_i.chars_held);
          check_field("led_bits", want.led_bits, out_i.led_bits);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(keyboard_result(in_i));
      end
      outstanding = expected_results.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode translator testbench
// Directed key sequences (shift, lock keys, modifiers, out-of-table codes,
// empty reads) followed by random typing in phases of differing read rate so
// the FIFO both drains and overflows. Sender bursts and receiver stalls are
// random, with one long receiver hold-off to back the block up.
// ----------------------------------------------------------------------------
module testbench;
  import sctc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned PHASE_READ_PCT [5] = '{2, 45, 70, 20, 90};

  // Directed sequence: empty read, typing, shift, caps fixups, lock keys,
  // modifiers, codes past the table, key zero, and a read with junk data
  localparam req_t DIRECTED [26] = '{
    {OP_READ, 8'h00},
    {OP_SCAN, 8'h1E},
    {OP_SCAN, 8'h9E},
    {OP_SCAN, 1'b0, KEY_LSHIFT},
    {OP_SCAN, 8'h02},
    {OP_SCAN, 1'b0, KEY_SLASH},
    {OP_SCAN, 1'b1, KEY_LSHIFT},
    {OP_SCAN, 1'b0, KEY_CAPS},
    {OP_SCAN, 1'b1, KEY_CAPS},
    {OP_SCAN, 1'b0, KEY_BSLASH},
    {OP_SCAN, 1'b0, KEY_PAD_LO},
    {OP_SCAN, 1'b0, KEY_RSHIFT},
    {OP_SCAN, 1'b0, KEY_SLASH},
    {OP_SCAN, 8'h10},
    {OP_SCAN, 1'b0, KEY_BSLASH},
    {OP_SCAN, 1'b1, KEY_RSHIFT},
    {OP_SCAN, 1'b0, KEY_NUM},
    {OP_SCAN, 1'b0, KEY_SCROLL},
    {OP_SCAN, 1'b1, KEY_SCROLL},
    {OP_SCAN, 1'b0, KEY_CTRL},
    {OP_SCAN, 1'b0, KEY_ALT},
    {OP_SCAN, 8'h54},
    {OP_SCAN, 8'h00},
    {OP_SCAN, 8'h53},
    {OP_SCAN, 8'hFF},
    {OP_READ, 8'hFF}
  };

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  logic in_stall;
  req_t in_req     = '0;
  logic out_valid;
  logic out_stall  = 1'b0;
  res_t out_res;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;

  scancode_to_char_with_buffer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_res)
  );

  sctc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_res),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: segments of free flow, light and heavy stalling, short holds;
  // the third segment is a long hold so the block fills and stalls its input
  initial begin
    int seg_len;
    int mode;
    int seg_idx;
    seg_idx = 0;
    @(posedge rst_ni);
    forever begin
      mode    = $urandom_range(3);
      seg_len = (mode == 3) ? $urandom_range(20, 60) : $urandom_range(20, 150);
      if (seg_idx == 2) begin
        mode    = 3;
        seg_len = LONG_HOLD;
      end
      repeat (seg_len) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(1) == 1);
          2: out_stall <= ($urandom_range(9) != 0);
          default: out_stall <= 1'b1;
        endcase
      end
      seg_idx++;
    end
  end

  // Offer one request and hold it until taken
  task automatic send_request(input req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Mostly plausible typing: key makes and breaks, shift and lock keys,
  // with reads at the phase's rate and some raw byte noise
  function automatic req_t random_request(input int unsigned read_pct);
    req_t       r;
    int unsigned pick;
    logic [6:0] key;
    r    = '0;
    r.op = OP_SCAN;
    pick = $urandom_range(99);
    if (pick < read_pct) begin
      r.op        = OP_READ;
      r.scan_byte = 8'($urandom_range(255));
    end else begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        case ($urandom_range(2))
          0: key = KEY_CAPS;
          1: key = KEY_NUM;
          default: key = KEY_SCROLL;
        endcase
        r.scan_byte = {($urandom_range(3) == 0), key};
      end else if (pick < 18) begin
        key         = ($urandom_range(1) == 1) ? KEY_LSHIFT : KEY_RSHIFT;
        r.scan_byte = {($urandom_range(1) == 1), key};
      end else if (pick < 28) begin
        r.scan_byte = 8'($urandom_range(255));
      end else begin
        key         = 7'($urandom_range(KEY_COUNT - 1));
        r.scan_byte = {($urandom_range(99) < 30), key};
      end
    end
    return r;
  endfunction

  // Stimulus and verdict
  initial begin
    int          sent;
    int          phase;
    int          phase_left;
    int          burst_left;
    int          gap;
    int unsigned read_pct;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_request(DIRECTED[i]);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      read_pct   = PHASE_READ_PCT[phase % 5];
      phase_left = $urandom_range(60, 140);
      while (phase_left > 0 && sent < RANDOM_ITEMS) begin
        burst_left = $urandom_range(1, 24);
        while (burst_left > 0 && phase_left > 0 && sent < RANDOM_ITEMS) begin
          send_request(random_request(read_pct));
          burst_left--;
          phase_left--;
          sent++;
        end
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sctc_pkg.sv
hw/rtl/sctc_xlate.sv
hw/rtl/sctc_fifo.sv
hw/rtl/sctc_outq.sv
hw/rtl/scancode_to_char_with_buffer.sv
hw/rtl/sctc_chk.sv
dv/sctc_checker.sv
dv/testbench.sv
